// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on the rising edge, held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SWS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define SWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/sws_pkg.sv =====
package sws_pkg;

    localparam int CHAN_W         = 8;
    localparam int PROD_W         = 2 * CHAN_W;
    localparam int BITS_PER_PIXEL = 3 * CHAN_W;
    localparam int SYM_CNT_W      = 5;
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_DIM_STEP   = CFG_INDEX_W'(1);

    localparam logic [CHAN_W-1:0] BRIGHTNESS_RESET = 8'd255;

    localparam logic [1:0] DIM_FULL    = 2'd0;  // x255
    localparam logic [1:0] DIM_THREEQ  = 2'd1;  // x192
    localparam logic [1:0] DIM_HALF    = 2'd2;  // x128
    localparam logic [1:0] DIM_QUARTER = 2'd3;  // x64

    typedef struct packed {
        logic              last;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_in_t;

    // bits: green, red, blue from the top byte down
    typedef struct packed {
        logic                      last;
        logic [BITS_PER_PIXEL-1:0] bits;
    } pixel_word_t;

    // (p * dim_factor) >> 16 with the factor built from shifts
    function automatic logic [CHAN_W-1:0] dim_scale(input logic [PROD_W-1:0] p,
                                                     input logic [1:0] step);
        logic [PROD_W+CHAN_W-1:0] wide;
        logic [PROD_W+CHAN_W-1:0] pe;
        pe = (PROD_W+CHAN_W)'(p);
        case (step)
            DIM_FULL:    wide = (pe << 8) - pe;
            DIM_THREEQ:  wide = (pe << 7) + (pe << 6);
            DIM_HALF:    wide = pe << 7;
            DIM_QUARTER: wide = pe << 6;
            default:     wide = '0;
        endcase
        return wide[PROD_W+CHAN_W-1:PROD_W];
    endfunction

endpackage

// ===== rtl/sws_front.sv =====
module sws_front
    import sws_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  pixel_in_t         in_pixel,
    input  logic [CHAN_W-1:0] brightness_limit,
    input  logic [1:0]        dim_step,
    output logic              out_valid,
    input  logic              out_ready,
    output pixel_word_t       out_word
);

    logic              p1_valid_reg, p1_valid_next;
    logic [PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic              last1_reg;
    logic              p2_valid_reg, p2_valid_next;
    pixel_word_t       word_reg;
    logic              p1_ready, p2_ready;

    assign p2_ready  = !p2_valid_reg || out_ready;
    assign p1_ready  = !p1_valid_reg || p2_ready;
    assign in_ready  = p1_ready;
    assign out_valid = p2_valid_reg;
    assign out_word  = word_reg;

    always_comb begin
        p1_valid_next = p1_valid_reg;
        p2_valid_next = p2_valid_reg;
        if (p1_ready) begin
            p1_valid_next = in_valid;
        end
        if (p2_ready) begin
            p2_valid_next = p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
        end
    end

    // stage 1: channel x brightness
    always_ff @(posedge aclk) begin
        if (p1_ready && in_valid) begin
            prod_r_reg <= in_pixel.red   * brightness_limit;
            prod_g_reg <= in_pixel.green * brightness_limit;
            prod_b_reg <= in_pixel.blue  * brightness_limit;
            last1_reg  <= in_pixel.last;
        end
    end

    // stage 2: dim factor, keep the high byte, pack G R B
    always_ff @(posedge aclk) begin
        if (p2_ready && p1_valid_reg) begin
            word_reg.bits <= {dim_scale(prod_g_reg, dim_step),
                              dim_scale(prod_r_reg, dim_step),
                              dim_scale(prod_b_reg, dim_step)};
            word_reg.last <= last1_reg;
        end
    end

endmodule

// ===== rtl/sws_queue.sv =====
module sws_queue
    import sws_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  pixel_word_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output pixel_word_t out_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pixel_word_t       mem_reg [DEPTH];
    logic [IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/sws_back.sv =====
module sws_back
    import sws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  pixel_word_t in_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_bit_code,
    output logic        m_latch,
    output logic        m_end
);

    localparam logic [SYM_CNT_W-1:0] LAST_BIT = SYM_CNT_W'(BITS_PER_PIXEL - 1);
    localparam logic [SYM_CNT_W-1:0] LATCH_SLOT = SYM_CNT_W'(BITS_PER_PIXEL);

    logic                      busy_reg, busy_next;
    logic [BITS_PER_PIXEL-1:0] shift_reg, shift_next;
    logic [SYM_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                      last_reg, last_next;
    logic                      valid_reg, valid_next;
    logic                      bit_reg, bit_next;
    logic                      latch_reg, latch_next;
    logic                      end_reg, end_next;
    logic                      advance;

    assign advance    = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign m_bit_code = bit_reg;
    assign m_latch    = latch_reg;
    assign m_end      = end_reg;

    always_comb begin
        busy_next  = busy_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        valid_next = valid_reg;
        bit_next   = bit_reg;
        latch_next = latch_reg;
        end_next   = end_reg;
        in_ready   = 1'b0;
        if (advance) begin
            valid_next = 1'b0;
            if (busy_reg) begin
                valid_next = 1'b1;
                if (cnt_reg == LATCH_SLOT) begin
                    bit_next   = 1'b0;
                    latch_next = 1'b1;
                    end_next   = 1'b1;
                    busy_next  = 1'b0;
                end else begin
                    bit_next   = shift_reg[BITS_PER_PIXEL-1];
                    latch_next = 1'b0;
                    end_next   = (cnt_reg == LAST_BIT) && !last_reg;
                    shift_next = {shift_reg[BITS_PER_PIXEL-2:0], 1'b0};
                    cnt_next   = cnt_reg + 1'b1;
                    if ((cnt_reg == LAST_BIT) && !last_reg) begin
                        busy_next = 1'b0;
                    end
                end
            end else if (in_valid) begin
                // first bit leaves straight from the queue head
                in_ready   = 1'b1;
                valid_next = 1'b1;
                bit_next   = in_data.bits[BITS_PER_PIXEL-1];
                latch_next = 1'b0;
                end_next   = 1'b0;
                shift_next = {in_data.bits[BITS_PER_PIXEL-2:0], 1'b0};
                cnt_next   = SYM_CNT_W'(1);
                last_next  = in_data.last;
                busy_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        last_reg  <= last_next;
        bit_reg   <= bit_next;
        latch_reg <= latch_next;
        end_reg   <= end_next;
    end

endmodule

// ===== rtl/scaled_ws2812_pixel_serializer.sv =====
// Pixel-to-symbol serializer for a WS2812-style LED strip. Each pixel transfer on s_ carries
// red, green and blue; every channel is scaled by brightness_limit and the dim factor picked
// by dim_step (255, 192, 128, 64), and the result leaves on m_ as 24 symbols, one per
// cycle while m_tready is high, green, red, blue, MSB first (m_tdata[0] = 1 for a one-code).
// A pixel sent with s_tlast adds a 25th latch symbol (m_tuser = 1). m_tlast marks the final
// symbol of each pixel. Throughput is one symbol per clock at the output register while
// m_tready is high; the two-stage scaler and a small pixel queue keep the next pixel
// ready so symbols run back to back. The first symbol passes both scaler stages and the
// queue. Register writes (index 0 brightness, 1 dim step) are meant for idle periods.
module scaled_ws2812_pixel_serializer
    import sws_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic                   s_tlast,   // last_pixel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // bit_code[0], zero[7:1]
    output logic                   m_tuser,   // latch
    output logic                   m_tlast,   // end_of_run
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CHAN_W-1:0] brightness_reg, brightness_next;
    logic [1:0]        dim_step_reg, dim_step_next;
    pixel_in_t         in_pixel;
    pixel_word_t       fq_word, qb_word;
    logic              fq_valid, fq_ready, qb_valid, qb_ready;
    logic              bit_code;

    assign cfg_ready = 1'b1;

    always_comb begin
        brightness_next = brightness_reg;
        dim_step_next   = dim_step_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BRIGHTNESS: brightness_next = cfg_data[CHAN_W-1:0];
                REG_DIM_STEP:   dim_step_next   = cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= BRIGHTNESS_RESET;
            dim_step_reg   <= DIM_FULL;
        end else begin
            brightness_reg <= brightness_next;
            dim_step_reg   <= dim_step_next;
        end
    end

    assign in_pixel.red   = s_tdata[7:0];
    assign in_pixel.green = s_tdata[15:8];
    assign in_pixel.blue  = s_tdata[23:16];
    assign in_pixel.last  = s_tlast;

    sws_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_pixel         (in_pixel),
        .brightness_limit (brightness_reg),
        .dim_step         (dim_step_reg),
        .out_valid        (fq_valid),
        .out_ready        (fq_ready),
        .out_word         (fq_word)
    );

    sws_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_word),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_word)
    );

    sws_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (qb_valid),
        .in_ready   (qb_ready),
        .in_data    (qb_word),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_bit_code (bit_code),
        .m_latch    (m_tuser),
        .m_end      (m_tlast)
    );

    assign m_tdata = {7'd0, bit_code};

endmodule

// ===== rtl/sws_checker.sv =====
`include "assert_macros.svh"

module sws_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    `SWS_ASSERT_NOW(a_latch_ends_run, aclk, aresetn, m_tvalid && m_tuser, m_tlast)
    `SWS_ASSERT_NOW(a_latch_zero_code, aclk, aresetn, m_tvalid && m_tuser, !m_tdata[0])
    `SWS_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[7:1] == 7'd0)
    `SWS_ASSERT_NEXT(a_latch_after_end, aclk, aresetn,
                     m_tvalid && m_tready && m_tuser, !(m_tvalid && m_tuser))
    `SWS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind scaled_ws2812_pixel_serializer sws_checker u_sws_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
